@@ hw/rtl/ils_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types, codes and defaults for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WIDTH_DEFAULT = 32;

    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_REAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT_AT = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE_AT = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    typedef enum logic [2:0] {
        REQ_NONE,
        REQ_ADD_FRONT,
        REQ_ADD_REAR,
        REQ_INS_MID,
        REQ_REM_FRONT,
        REQ_REM_REAR,
        REQ_REM_MID
    } req_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_FRONT_OUT,
        S_REAR_OUT,
        S_MID_VICTIM,
        S_MID_OUT,
        S_RELEASE,
        S_INS_NEXT,
        S_ALLOC,
        S_ADD_FRONT,
        S_ADD_REAR,
        S_INS_LINK,
        S_INS_PREV,
        S_RESULT
    } state_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DECODE,
        ACT_WALK,
        ACT_FRONT_OUT,
        ACT_REAR_OUT,
        ACT_MID_VICTIM,
        ACT_MID_OUT,
        ACT_RELEASE,
        ACT_INS_NEXT,
        ACT_ALLOC,
        ACT_ADD_FRONT,
        ACT_ADD_REAR,
        ACT_INS_LINK,
        ACT_INS_PREV
    } action_t;

    typedef struct packed {
        action_t action;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        req_kind_t kind;
        logic      walk_zero;
        logic      walk_last;
    } dp_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/ils_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_ram
// Generic memory with one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module ils_ram #(
    parameter int DATA_W = ils_pkg::WIDTH_DEFAULT,
    parameter int DEPTH  = ils_pkg::DEPTH_DEFAULT
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [DATA_W-1:0]          wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [DATA_W-1:0]          rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/ils_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_ctrl
// Request sequencer and result handshake for the indexed list store.
// ----------------------------------------------------------------------------
module ils_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire ils_pkg::dp_status_t sts,
    output ils_pkg::ctrl_cmd_t      cmd
);

    ils_pkg::state_t state_reg, state_next;
    ils_pkg::state_t after_walk;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (sts.kind)
            ils_pkg::REQ_REM_REAR: after_walk = ils_pkg::S_REAR_OUT;
            ils_pkg::REQ_REM_MID:  after_walk = ils_pkg::S_MID_VICTIM;
            default:               after_walk = ils_pkg::S_INS_NEXT;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ils_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = ils_pkg::S_DECODE;
                end
            end
            ils_pkg::S_DECODE: begin
                case (sts.kind)
                    ils_pkg::REQ_ADD_FRONT, ils_pkg::REQ_ADD_REAR: begin
                        state_next = ils_pkg::S_ALLOC;
                    end
                    ils_pkg::REQ_REM_FRONT: state_next = ils_pkg::S_FRONT_OUT;
                    ils_pkg::REQ_REM_REAR, ils_pkg::REQ_REM_MID, ils_pkg::REQ_INS_MID: begin
                        state_next = sts.walk_zero ? after_walk : ils_pkg::S_WALK;
                    end
                    default: state_next = ils_pkg::S_RESULT;
                endcase
            end
            ils_pkg::S_WALK: begin
                if (sts.walk_last) begin
                    state_next = after_walk;
                end
            end
            ils_pkg::S_FRONT_OUT:  state_next = ils_pkg::S_RESULT;
            ils_pkg::S_REAR_OUT:   state_next = ils_pkg::S_RESULT;
            ils_pkg::S_MID_VICTIM: state_next = ils_pkg::S_MID_OUT;
            ils_pkg::S_MID_OUT:    state_next = ils_pkg::S_RELEASE;
            ils_pkg::S_RELEASE:    state_next = ils_pkg::S_RESULT;
            ils_pkg::S_INS_NEXT:   state_next = ils_pkg::S_ALLOC;
            ils_pkg::S_ALLOC: begin
                case (sts.kind)
                    ils_pkg::REQ_ADD_FRONT: state_next = ils_pkg::S_ADD_FRONT;
                    ils_pkg::REQ_ADD_REAR:  state_next = ils_pkg::S_ADD_REAR;
                    default:                state_next = ils_pkg::S_INS_LINK;
                endcase
            end
            ils_pkg::S_ADD_FRONT:  state_next = ils_pkg::S_RESULT;
            ils_pkg::S_ADD_REAR:   state_next = ils_pkg::S_RESULT;
            ils_pkg::S_INS_LINK:   state_next = ils_pkg::S_INS_PREV;
            ils_pkg::S_INS_PREV:   state_next = ils_pkg::S_RESULT;
            ils_pkg::S_RESULT: begin
                if (out_free) begin
                    state_next = ils_pkg::S_IDLE;
                end
            end
            default: state_next = ils_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd.action   = ils_pkg::ACT_NONE;
        cmd.out_load = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            ils_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.action = ils_pkg::ACT_LOAD;
                end
            end
            ils_pkg::S_DECODE:     cmd.action = ils_pkg::ACT_DECODE;
            ils_pkg::S_WALK:       cmd.action = ils_pkg::ACT_WALK;
            ils_pkg::S_FRONT_OUT:  cmd.action = ils_pkg::ACT_FRONT_OUT;
            ils_pkg::S_REAR_OUT:   cmd.action = ils_pkg::ACT_REAR_OUT;
            ils_pkg::S_MID_VICTIM: cmd.action = ils_pkg::ACT_MID_VICTIM;
            ils_pkg::S_MID_OUT:    cmd.action = ils_pkg::ACT_MID_OUT;
            ils_pkg::S_RELEASE:    cmd.action = ils_pkg::ACT_RELEASE;
            ils_pkg::S_INS_NEXT:   cmd.action = ils_pkg::ACT_INS_NEXT;
            ils_pkg::S_ALLOC:      cmd.action = ils_pkg::ACT_ALLOC;
            ils_pkg::S_ADD_FRONT:  cmd.action = ils_pkg::ACT_ADD_FRONT;
            ils_pkg::S_ADD_REAR:   cmd.action = ils_pkg::ACT_ADD_REAR;
            ils_pkg::S_INS_LINK:   cmd.action = ils_pkg::ACT_INS_LINK;
            ils_pkg::S_INS_PREV:   cmd.action = ils_pkg::ACT_INS_PREV;
            ils_pkg::S_RESULT:     cmd.out_load = out_free;
            default:               cmd.action = ils_pkg::ACT_NONE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (state_reg == ils_pkg::S_RESULT && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ils_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

@@ hw/rtl/ils_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_datapath
// List pointers, free slot chain, link walker and result registers, with the
// element and link memories.
// ----------------------------------------------------------------------------
module ils_datapath #(
    parameter int DEPTH = ils_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = ils_pkg::WIDTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ils_pkg::ctrl_cmd_t            cmd,
    output ils_pkg::dp_status_t                sts,
    input  wire logic [ils_pkg::OP_W-1:0]      s_operation,
    input  wire logic [ils_pkg::POS_W-1:0]     s_position,
    input  wire logic [ils_pkg::VAL_W-1:0]     s_value,
    output logic      [ils_pkg::VAL_W-1:0]     m_removed_value,
    output logic      [ils_pkg::STAT_W-1:0]    m_status,
    output logic      [ils_pkg::CNT_W-1:0]     m_item_count
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW  = ((CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W) + 1;
    localparam int VXW = WIDTH + ils_pkg::VAL_W;
    localparam int NXW = CW + ils_pkg::CNT_W;

    logic [ils_pkg::OP_W-1:0]   op_reg, op_next;
    logic [ils_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [WIDTH-1:0]           val_reg, val_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [AW-1:0]              tail_reg, tail_next;
    logic [AW-1:0]              free_head_reg, free_head_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              fresh_reg, fresh_next;
    logic [AW-1:0]              cur_reg, cur_next;
    logic [AW-1:0]              victim_reg, victim_next;
    logic [AW-1:0]              nxt_reg, nxt_next;
    logic [AW-1:0]              new_slot_reg, new_slot_next;
    logic                       from_free_reg, from_free_next;
    logic [CW-1:0]              steps_reg, steps_next;
    logic [WIDTH-1:0]           removed_reg, removed_next;
    logic [ils_pkg::STAT_W-1:0] status_reg, status_next;

    logic [ils_pkg::VAL_W-1:0]  out_removed_reg;
    logic [ils_pkg::STAT_W-1:0] out_status_reg;
    logic [ils_pkg::CNT_W-1:0]  out_count_reg;

    logic [PW-1:0]              pos_x, cnt_x, walk_k;
    logic                       full;
    ils_pkg::req_kind_t         kind;
    logic [ils_pkg::STAT_W-1:0] dec_status;
    logic                       pop;
    logic [VXW-1:0]             s_value_x, removed_x;
    logic [NXW-1:0]             count_x;

    logic             link_we, link_re;
    logic [AW-1:0]    link_waddr, link_wdata, link_raddr, link_rdata;
    logic             elem_we, elem_re;
    logic [AW-1:0]    elem_waddr, elem_raddr;
    logic [WIDTH-1:0] elem_rdata;

    assign pos_x = PW'(pos_reg);
    assign cnt_x = PW'(count_reg);
    assign full  = (count_reg == CW'(DEPTH));

    always_comb begin
        kind       = ils_pkg::REQ_NONE;
        dec_status = ils_pkg::ST_OK;
        case (op_reg)
            ils_pkg::OP_ADD_FRONT: begin
                if (full) begin
                    dec_status = ils_pkg::ST_FULL;
                end else begin
                    kind = ils_pkg::REQ_ADD_FRONT;
                end
            end
            ils_pkg::OP_ADD_REAR: begin
                if (full) begin
                    dec_status = ils_pkg::ST_FULL;
                end else begin
                    kind = ils_pkg::REQ_ADD_REAR;
                end
            end
            ils_pkg::OP_REM_FRONT: begin
                if (count_reg == '0) begin
                    dec_status = ils_pkg::ST_UNDERFLOW;
                end else begin
                    kind = ils_pkg::REQ_REM_FRONT;
                end
            end
            ils_pkg::OP_REM_REAR: begin
                if (count_reg == '0) begin
                    dec_status = ils_pkg::ST_UNDERFLOW;
                end else if (count_reg == CW'(1)) begin
                    kind = ils_pkg::REQ_REM_FRONT;
                end else begin
                    kind = ils_pkg::REQ_REM_REAR;
                end
            end
            ils_pkg::OP_INSERT_AT: begin
                if (pos_reg == '0 || pos_x > cnt_x + PW'(1)) begin
                    dec_status = ils_pkg::ST_RANGE;
                end else if (full) begin
                    dec_status = ils_pkg::ST_FULL;
                end else if (pos_x == PW'(1)) begin
                    kind = ils_pkg::REQ_ADD_FRONT;
                end else if (pos_x == cnt_x + PW'(1)) begin
                    kind = ils_pkg::REQ_ADD_REAR;
                end else begin
                    kind = ils_pkg::REQ_INS_MID;
                end
            end
            ils_pkg::OP_REMOVE_AT: begin
                if (pos_reg == '0 || pos_x > cnt_x) begin
                    dec_status = ils_pkg::ST_RANGE;
                end else if (pos_x == PW'(1)) begin
                    kind = ils_pkg::REQ_REM_FRONT;
                end else if (pos_x == cnt_x) begin
                    kind = ils_pkg::REQ_REM_REAR;
                end else begin
                    kind = ils_pkg::REQ_REM_MID;
                end
            end
            default: begin
                kind       = ils_pkg::REQ_NONE;
                dec_status = ils_pkg::ST_OK;
            end
        endcase
    end

    assign walk_k = (kind == ils_pkg::REQ_REM_REAR) ? (cnt_x - PW'(2)) : (pos_x - PW'(2));

    assign sts.kind      = kind;
    assign sts.walk_zero = (walk_k == '0);
    assign sts.walk_last = (steps_reg == CW'(1));

    always_comb begin
        link_we    = 1'b0;
        link_waddr = cur_reg;
        link_wdata = free_head_reg;
        link_re    = 1'b0;
        link_raddr = head_reg;
        elem_re    = 1'b0;
        elem_raddr = head_reg;
        case (cmd.action)
            ils_pkg::ACT_DECODE: begin
                link_re    = 1'b1;
                elem_re    = 1'b1;
                elem_raddr = (kind == ils_pkg::REQ_REM_REAR) ? tail_reg : head_reg;
            end
            ils_pkg::ACT_WALK: begin
                link_re    = 1'b1;
                link_raddr = link_rdata;
            end
            ils_pkg::ACT_MID_VICTIM: begin
                link_re    = 1'b1;
                link_raddr = link_rdata;
                elem_re    = 1'b1;
                elem_raddr = link_rdata;
            end
            ils_pkg::ACT_ALLOC: begin
                link_re    = 1'b1;
                link_raddr = free_head_reg;
            end
            ils_pkg::ACT_FRONT_OUT: begin
                link_we = 1'b1;
            end
            ils_pkg::ACT_REAR_OUT: begin
                link_we    = 1'b1;
                link_waddr = tail_reg;
            end
            ils_pkg::ACT_MID_OUT: begin
                link_we    = 1'b1;
                link_wdata = link_rdata;
            end
            ils_pkg::ACT_RELEASE: begin
                link_we    = 1'b1;
                link_waddr = victim_reg;
            end
            ils_pkg::ACT_ADD_FRONT: begin
                link_we    = 1'b1;
                link_waddr = new_slot_reg;
                link_wdata = head_reg;
            end
            ils_pkg::ACT_ADD_REAR: begin
                link_we    = (count_reg != '0);
                link_waddr = tail_reg;
                link_wdata = new_slot_reg;
            end
            ils_pkg::ACT_INS_LINK: begin
                link_we    = 1'b1;
                link_waddr = new_slot_reg;
                link_wdata = nxt_reg;
            end
            ils_pkg::ACT_INS_PREV: begin
                link_we    = 1'b1;
                link_wdata = new_slot_reg;
            end
            default: begin
                link_we = 1'b0;
                link_re = 1'b0;
            end
        endcase
    end

    assign pop        = cmd.action inside {ils_pkg::ACT_ADD_FRONT, ils_pkg::ACT_ADD_REAR,
                                           ils_pkg::ACT_INS_LINK};
    assign elem_we    = pop;
    assign elem_waddr = new_slot_reg;
    assign s_value_x  = VXW'(s_value);

    always_comb begin
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        fresh_next     = fresh_reg;
        cur_next       = cur_reg;
        victim_next    = victim_reg;
        nxt_next       = nxt_reg;
        new_slot_next  = new_slot_reg;
        from_free_next = from_free_reg;
        steps_next     = steps_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        case (cmd.action)
            ils_pkg::ACT_LOAD: begin
                op_next  = s_operation;
                pos_next = s_position;
                val_next = s_value_x[WIDTH-1:0];
            end
            ils_pkg::ACT_DECODE: begin
                status_next  = dec_status;
                removed_next = '0;
                cur_next     = head_reg;
                steps_next   = walk_k[CW-1:0];
            end
            ils_pkg::ACT_WALK: begin
                cur_next   = link_rdata;
                steps_next = steps_reg - CW'(1);
            end
            ils_pkg::ACT_FRONT_OUT: begin
                removed_next   = elem_rdata;
                free_head_next = cur_reg;
                count_next     = count_reg - CW'(1);
                if (count_reg != CW'(1)) begin
                    head_next = link_rdata;
                end
            end
            ils_pkg::ACT_REAR_OUT: begin
                removed_next   = elem_rdata;
                free_head_next = tail_reg;
                tail_next      = cur_reg;
                count_next     = count_reg - CW'(1);
            end
            ils_pkg::ACT_MID_VICTIM: begin
                victim_next = link_rdata;
            end
            ils_pkg::ACT_MID_OUT: begin
                removed_next = elem_rdata;
                count_next   = count_reg - CW'(1);
            end
            ils_pkg::ACT_RELEASE: begin
                free_head_next = victim_reg;
            end
            ils_pkg::ACT_INS_NEXT: begin
                nxt_next = link_rdata;
            end
            ils_pkg::ACT_ALLOC: begin
                from_free_next = (fresh_reg != count_reg);
                new_slot_next  = (fresh_reg != count_reg) ? free_head_reg : fresh_reg[AW-1:0];
            end
            ils_pkg::ACT_ADD_FRONT: begin
                head_next  = new_slot_reg;
                count_next = count_reg + CW'(1);
                if (count_reg == '0) begin
                    tail_next = new_slot_reg;
                end
            end
            ils_pkg::ACT_ADD_REAR: begin
                tail_next  = new_slot_reg;
                count_next = count_reg + CW'(1);
                if (count_reg == '0) begin
                    head_next = new_slot_reg;
                end
            end
            ils_pkg::ACT_INS_PREV: begin
                count_next = count_reg + CW'(1);
            end
            default: begin
                op_next = op_reg;
            end
        endcase
        if (pop) begin
            if (from_free_reg) begin
                free_head_next = link_rdata;
            end else begin
                fresh_next = fresh_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            free_head_reg <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        cur_reg       <= cur_next;
        victim_reg    <= victim_next;
        nxt_reg       <= nxt_next;
        new_slot_reg  <= new_slot_next;
        from_free_reg <= from_free_next;
        steps_reg     <= steps_next;
        removed_reg   <= removed_next;
        status_reg    <= status_next;
    end

    assign removed_x = VXW'(removed_reg);
    assign count_x   = NXW'(count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_removed_reg <= removed_x[ils_pkg::VAL_W-1:0];
            out_status_reg  <= status_reg;
            out_count_reg   <= count_x[ils_pkg::CNT_W-1:0];
        end
    end

    assign m_removed_value = out_removed_reg;
    assign m_status        = out_status_reg;
    assign m_item_count    = out_count_reg;

    ils_ram #(
        .DATA_W (WIDTH),
        .DEPTH  (DEPTH)
    ) u_elem_ram (
        .aclk  (aclk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (val_reg),
        .re    (elem_re),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    ils_ram #(
        .DATA_W (AW),
        .DEPTH  (DEPTH)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

endmodule
`default_nettype wire

@@ hw/rtl/indexed_list_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store
// Bounded ordered list kept as a singly linked chain of slots in memory.
//
//   Channel   Direction   Ports
//   request   in          s_valid, s_ready, s_operation, s_position, s_value
//   result    out         m_valid, m_ready, m_removed_value, m_status,
//                         m_item_count
//
// One request is in work at a time. A rejected request or an unused code goes from
// decode straight to the result; a rear or middle removal and a middle insert may
// first walk the links one slot per cycle. Synchronous reset (aresetn low) empties
// the list at once. A result that waits in the output register does not block the
// next request, whose result waits for it.
// ----------------------------------------------------------------------------
module indexed_list_store #(
    parameter int DEPTH = ils_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = ils_pkg::WIDTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ils_pkg::OP_W-1:0]      s_operation,
    input  wire logic [ils_pkg::POS_W-1:0]     s_position,
    input  wire logic [ils_pkg::VAL_W-1:0]     s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [ils_pkg::VAL_W-1:0]     m_removed_value,
    output logic      [ils_pkg::STAT_W-1:0]    m_status,
    output logic      [ils_pkg::CNT_W-1:0]     m_item_count
);

    localparam int CNT_W = ils_pkg::CNT_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    ils_pkg::ctrl_cmd_t  cmd;
    ils_pkg::dp_status_t sts;

    ils_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ils_datapath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_operation     (s_operation),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_removed_value (m_removed_value),
        .m_status        (m_status),
        .m_item_count    (m_item_count)
    );

    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (cmd.action == ils_pkg::ACT_DECODE) && !s_ready)
        else $error("accepted request was not decoded in the next cycle");

    a_fail_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ils_pkg::ST_OK) |-> (m_removed_value == '0))
        else $error("failed request returned a nonzero removed value");

    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ils_pkg::ST_UNDERFLOW) |-> (m_item_count == '0))
        else $error("underflow reported while elements are held");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ils_pkg::ST_FULL) |-> (m_item_count == FULL_COUNT))
        else $error("full reported with a count below capacity");

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed list store. A directed table covers the
// empty, out-of-range and unused-code cases and the field extremes. Random
// phases follow that fill, drain and mix the list, with some noise. Every
// accepted request is run through an ordered-list predictor, and each result
// transfer is compared field by field with the oldest expected result. Both
// channels idle at random, and the result side holds off for long stretches.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIST_DEPTH   = ils_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_LIMIT  = 3000;
    localparam int RX_HOLD      = 300;
    localparam int DRAIN_CYCLES = 4 * (LIST_DEPTH + 4);

    localparam logic [ils_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [ils_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED,
        PH_NOISE
    } phase_t;

    typedef struct packed {
        logic [ils_pkg::VAL_W-1:0]  removed;
        logic [ils_pkg::STAT_W-1:0] status;
        logic [ils_pkg::CNT_W-1:0]  count;
    } list_result_t;

    typedef struct packed {
        logic [ils_pkg::OP_W-1:0]  op;
        logic [ils_pkg::POS_W-1:0] pos;
        logic [ils_pkg::VAL_W-1:0] val;
        logic                      typed;
        list_result_t              res;
    } stim_row_t;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    logic [ils_pkg::OP_W-1:0]    s_operation = '0;
    logic [ils_pkg::POS_W-1:0]   s_position  = '0;
    logic [ils_pkg::VAL_W-1:0]   s_value     = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    logic [ils_pkg::VAL_W-1:0]   m_removed_value;
    logic [ils_pkg::STAT_W-1:0]  m_status;
    logic [ils_pkg::CNT_W-1:0]   m_item_count;

    logic [ils_pkg::VAL_W-1:0]   list_q[$];
    list_result_t                pending_results[$];
    int                          fail_count = 0;
    int                          result_index = 0;
    bit                          tx_calm = 1'b0;

    indexed_list_store u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_removed_value (m_removed_value),
        .m_status        (m_status),
        .m_item_count    (m_item_count)
    );

    always #2 aclk = ~aclk;

    function automatic list_result_t apply_request(input logic [ils_pkg::OP_W-1:0] op,
                                                   input logic [ils_pkg::POS_W-1:0] pos,
                                                   input logic [ils_pkg::VAL_W-1:0] val);
        list_result_t r;
        int n;
        int p;
        r.removed = '0;
        r.status  = ils_pkg::ST_OK;
        n = list_q.size();
        p = int'(pos);
        case (op)
            ils_pkg::OP_ADD_FRONT, ils_pkg::OP_ADD_REAR: begin
                if (n >= LIST_DEPTH) r.status = ils_pkg::ST_FULL;
                else if (op == ils_pkg::OP_ADD_FRONT) list_q.push_front(val);
                else list_q.push_back(val);
            end
            ils_pkg::OP_REM_FRONT: begin
                if (n == 0) r.status = ils_pkg::ST_UNDERFLOW;
                else r.removed = list_q.pop_front();
            end
            ils_pkg::OP_REM_REAR: begin
                if (n == 0) r.status = ils_pkg::ST_UNDERFLOW;
                else r.removed = list_q.pop_back();
            end
            ils_pkg::OP_INSERT_AT: begin
                if (p < 1 || p > n + 1) r.status = ils_pkg::ST_RANGE;
                else if (n >= LIST_DEPTH) r.status = ils_pkg::ST_FULL;
                else list_q.insert(p - 1, val);
            end
            ils_pkg::OP_REMOVE_AT: begin
                if (p < 1 || p > n) begin
                    r.status = ils_pkg::ST_RANGE;
                end else begin
                    r.removed = list_q[p - 1];
                    list_q.delete(p - 1);
                end
            end
            default: ;
        endcase
        r.count = ils_pkg::CNT_W'(list_q.size());
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic [ils_pkg::OP_W-1:0] op,
                                input logic [ils_pkg::POS_W-1:0] pos,
                                input logic [ils_pkg::VAL_W-1:0] val, input logic typed,
                                input list_result_t typed_res);
        list_result_t pred;
        int gap;
        s_operation <= op;
        s_position  <= pos;
        s_value     <= val;
        s_valid     <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pred = apply_request(op, pos, val);
        pending_results.push_back(typed ? typed_res : pred);
        gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            result_index++;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result %0d: removed=%h status=%0d count=%0d",
                             result_index, m_removed_value, m_status, m_item_count);
            end else begin
                want = pending_results.pop_front();
                if (m_removed_value !== want.removed || m_status !== want.status ||
                        m_item_count !== want.count) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch at result %0d: exp %h/%0d/%0d got %h/%0d/%0d",
                                 result_index, want.removed, want.status, want.count,
                                 m_removed_value, m_status, m_item_count);
                end
            end
        end
    end

    initial begin : result_sink
        int stretch;
        int gap;
        int seen;
        int next_hold;
        bit calm;
        seen = 0;
        next_hold = 400;
        @(posedge aclk iff aresetn);
        forever begin
            calm = ($urandom_range(0, 3) == 0);
            stretch = $urandom_range(30, 150);
            while (stretch > 0) begin
                if (seen >= next_hold) begin
                    m_ready <= 1'b0;
                    repeat (RX_HOLD) @(posedge aclk);
                    next_hold += 600;
                    stretch = 0;
                end else if (!calm && $urandom_range(0, 3) == 0) begin
                    gap = pick_gap();
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                    stretch -= gap;
                end else begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                    if (m_valid && m_ready) seen++;
                    stretch--;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("testbench failed");
        $finish;
    end

    initial begin : stimulus
        stim_row_t directed_tab[$];
        phase_t phase;
        logic [ils_pkg::OP_W-1:0] op;
        logic [ils_pkg::POS_W-1:0] pos;
        logic [ils_pkg::VAL_W-1:0] val;
        int sent;
        int phase_len;
        int phase_no;
        int n;
        int r;

        directed_tab = '{
            {ils_pkg::OP_REM_FRONT, 5'd0,  32'h0000_0000, 1'b1, 32'd0, ils_pkg::ST_UNDERFLOW, 5'd0},
            {ils_pkg::OP_REM_REAR,  5'd0,  32'hFFFF_FFFF, 1'b1, 32'd0, ils_pkg::ST_UNDERFLOW, 5'd0},
            {ils_pkg::OP_REMOVE_AT, 5'd1,  32'h0000_0000, 1'b1, 32'd0, ils_pkg::ST_RANGE,     5'd0},
            {ils_pkg::OP_INSERT_AT, 5'd0,  32'h1111_1111, 1'b1, 32'd0, ils_pkg::ST_RANGE,     5'd0},
            {ils_pkg::OP_INSERT_AT, 5'd2,  32'h2222_2222, 1'b1, 32'd0, ils_pkg::ST_RANGE,     5'd0},
            {OP_SPARE_6,            5'd31, 32'hFFFF_FFFF, 1'b1, 32'd0, ils_pkg::ST_OK,        5'd0},
            {OP_SPARE_7,            5'd1,  32'h0000_0000, 1'b1, 32'd0, ils_pkg::ST_OK,        5'd0},
            {ils_pkg::OP_INSERT_AT, 5'd1,  32'hFFFF_FFFF, 1'b1, 32'd0, ils_pkg::ST_OK,        5'd1},
            {ils_pkg::OP_ADD_FRONT, 5'd0,  32'h0000_0000, 1'b1, 32'd0, ils_pkg::ST_OK,        5'd2},
            {ils_pkg::OP_ADD_REAR,  5'd31, 32'h8000_0001, 1'b1, 32'd0, ils_pkg::ST_OK,        5'd3},
            {ils_pkg::OP_INSERT_AT, 5'd2,  32'h5555_AAAA, 1'b0, 32'd0, ils_pkg::ST_OK,        5'd0},
            {ils_pkg::OP_INSERT_AT, 5'd5,  32'h1234_5678, 1'b0, 32'd0, ils_pkg::ST_OK,        5'd0},
            {ils_pkg::OP_INSERT_AT, 5'd31, 32'hDEAD_BEEF, 1'b1, 32'd0, ils_pkg::ST_RANGE,     5'd5},
            {ils_pkg::OP_REMOVE_AT, 5'd0,  32'h0000_0000, 1'b1, 32'd0, ils_pkg::ST_RANGE,     5'd5},
            {ils_pkg::OP_REMOVE_AT, 5'd31, 32'h0000_0000, 1'b1, 32'd0, ils_pkg::ST_RANGE,     5'd5},
            {ils_pkg::OP_REMOVE_AT, 5'd6,  32'h0000_0000, 1'b1, 32'd0, ils_pkg::ST_RANGE,     5'd5},
            {ils_pkg::OP_REMOVE_AT, 5'd3,  32'h0000_0000, 1'b0, 32'd0, ils_pkg::ST_OK,        5'd0},
            {ils_pkg::OP_REMOVE_AT, 5'd4,  32'h0000_0000, 1'b0, 32'd0, ils_pkg::ST_OK,        5'd0},
            {ils_pkg::OP_REMOVE_AT, 5'd1,  32'h0000_0000, 1'b0, 32'd0, ils_pkg::ST_OK,        5'd0},
            {ils_pkg::OP_REM_REAR,  5'd0,  32'h0000_0000, 1'b0, 32'd0, ils_pkg::ST_OK,        5'd0},
            {ils_pkg::OP_REM_FRONT, 5'd0,  32'h0000_0000, 1'b0, 32'd0, ils_pkg::ST_OK,        5'd0},
            {ils_pkg::OP_ADD_REAR,  5'd0,  32'hA5A5_5A5A, 1'b0, 32'd0, ils_pkg::ST_OK,        5'd0},
            {ils_pkg::OP_REM_REAR,  5'd0,  32'h0000_0000, 1'b0, 32'd0, ils_pkg::ST_OK,        5'd0},
            {ils_pkg::OP_ADD_FRONT, 5'd0,  32'h0F0F_F0F0, 1'b0, 32'd0, ils_pkg::ST_OK,        5'd0},
            {ils_pkg::OP_REMOVE_AT, 5'd1,  32'h0000_0000, 1'b0, 32'd0, ils_pkg::ST_OK,        5'd0}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_tab[i])
            send_request(directed_tab[i].op, directed_tab[i].pos, directed_tab[i].val,
                         directed_tab[i].typed, directed_tab[i].res);

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_no++;
            phase = phase_t'($urandom_range(0, 3));
            if (phase == PH_NOISE && $urandom_range(0, 1) == 0) phase = PH_MIXED;
            tx_calm = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(10, 60);
            if (phase_no % 5 == 0 && pending_results.size() != 0) begin
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            repeat (phase_len) begin
                n = list_q.size();
                r = $urandom_range(0, 9);
                case (phase)
                    PH_FILL: begin
                        if (r < 3) op = ils_pkg::OP_ADD_FRONT;
                        else if (r < 6) op = ils_pkg::OP_ADD_REAR;
                        else if (r < 9) op = ils_pkg::OP_INSERT_AT;
                        else op = ils_pkg::OP_REMOVE_AT;
                    end
                    PH_DRAIN: begin
                        if (r < 3) op = ils_pkg::OP_REM_FRONT;
                        else if (r < 6) op = ils_pkg::OP_REM_REAR;
                        else if (r < 9) op = ils_pkg::OP_REMOVE_AT;
                        else op = ils_pkg::OP_ADD_REAR;
                    end
                    PH_MIXED: op = ils_pkg::OP_W'($urandom_range(0, 5));
                    default:  op = ils_pkg::OP_W'($urandom_range(0, 7));
                endcase
                if (phase == PH_NOISE || $urandom_range(0, 15) == 0)
                    pos = ils_pkg::POS_W'($urandom_range(0, 31));
                else if (op == ils_pkg::OP_INSERT_AT)
                    pos = ils_pkg::POS_W'($urandom_range(1, n + 1));
                else if (n == 0)
                    pos = 5'd1;
                else
                    pos = ils_pkg::POS_W'($urandom_range(1, n));
                r = $urandom_range(0, 15);
                if (r == 0) val = '0;
                else if (r == 1) val = '1;
                else val = $urandom;
                send_request(op, pos, val, 1'b0, '0);
                sent++;
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ils_pkg.sv
hw/rtl/ils_ram.sv
hw/rtl/ils_ctrl.sv
hw/rtl/ils_datapath.sv
hw/rtl/indexed_list_store.sv
bench/testbench.sv
